// File: src/cbsw_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbsw_pkg: shared types and constants
// Word formats, register map and fixed-point constants of the cubic B-spline
// basis weight core.
// ---------------------------------------------------------------------------
package cbsw_pkg;

   localparam int TIME_BITS              = 32;
   localparam int WEIGHT_FRAC_BITS       = 16;
   localparam int MAX_CONTROL_POINTS_DEF = 64;
   localparam int CP_BITS                = 6;
   localparam int COUNT_BITS             = 7;
   localparam int MIN_CONTROL_POINTS     = 4;
   localparam int CSR_ADDR_W             = 4;
   localparam int CSR_DATA_W             = 32;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_NUM_CP   = 2'd0;
   localparam logic [1:0] REG_WIN_BEG  = 2'd1;
   localparam logic [1:0] REG_WIN_END  = 2'd2;

   localparam logic [COUNT_BITS-1:0] NUM_CP_RESET  = COUNT_BITS'(MIN_CONTROL_POINTS);
   localparam logic [TIME_BITS-1:0]  WIN_BEG_RESET = '0;
   localparam logic [TIME_BITS-1:0]  WIN_END_RESET = '1;

   // numerator of the final divide by six: up to 7 * 2^F + 3
   localparam int WVAL_W = WEIGHT_FRAC_BITS + 3;
   localparam logic [WVAL_W-1:0] RECIP6 = WVAL_W'(((64'd1) << WVAL_W) / 64'd6);

   // largest weight any point can take (inner weight at u = 0)
   localparam logic [WEIGHT_FRAC_BITS-1:0] WEIGHT_MAX =
      WEIGHT_FRAC_BITS'(((64'd4 << WEIGHT_FRAC_BITS) + 64'd3) / 64'd6);

   typedef struct packed {
      logic [CP_BITS-1:0]   cp_index;
      logic [TIME_BITS-1:0] sample_time;
   } req_word_type;

   typedef struct packed {
      logic [WEIGHT_FRAC_BITS-1:0] weight;
      logic                        in_support;
   } rsp_word_type;

endpackage
`default_nettype wire

// File: src/cubic_bspline_basis_weight_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cubic_bspline_basis_weight_core: uniform cubic B-spline basis weight
// Returns one control point's basis weight (unsigned Q0.16) and a support
// flag for a sample time inside a configurable, evenly split window.
//
//   port group | dir    | word
//   -----------+--------+----------------------------------------------
//   req_       | in     | cp_index, sample_time (valid/ready)
//   rsp_       | out    | weight, in_support (valid/ready)
//   csr_       | in/out | APB-style: count @0x0, start @0x4, end @0x8
//
// One word per clock sustained while rsp_ready stays high: the divider is a
// row of NSEG_W + 16 cells, one quotient bit per cell, and the basis
// polynomial takes six stages.
// Synchronous reset clears all valids and loads the register reset values.
// A low rsp_ready stalls only the final word; bubbles further up close and
// req_ready falls once every stage holds a word.
// ---------------------------------------------------------------------------
module cubic_bspline_basis_weight_core #(
   parameter int MAX_CONTROL_POINTS = cbsw_pkg::MAX_CONTROL_POINTS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  cbsw_pkg::req_word_type         req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output cbsw_pkg::rsp_word_type               rsp_data,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [cbsw_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [cbsw_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cbsw_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import cbsw_pkg::*;

   localparam int COUNT_TOP = (1 << COUNT_BITS) - 1;
   localparam int CP_CAP    = (MAX_CONTROL_POINTS < COUNT_TOP) ? MAX_CONTROL_POINTS
                                                               : COUNT_TOP;
   localparam int NSEG_W    = $clog2(CP_CAP - 2);
   localparam int QW        = NSEG_W + WEIGHT_FRAC_BITS;

   localparam logic [COUNT_BITS-1:0] CP_CAP_C = COUNT_BITS'(CP_CAP);
   localparam logic [COUNT_BITS-1:0] CP_MIN_C = COUNT_BITS'(MIN_CONTROL_POINTS);

   logic [COUNT_BITS-1:0] num_cp_ff;
   logic [TIME_BITS-1:0]  win_beg_ff, win_end_ff;
   logic                  csr_write;
   logic [1:0]            csr_index;
   logic [COUNT_BITS-1:0] count_eff;
   logic [NSEG_W-1:0]     nseg;
   logic [TIME_BITS-1:0]  span;

   // ---- register file ----
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cp_ff  <= NUM_CP_RESET;
         win_beg_ff <= WIN_BEG_RESET;
         win_end_ff <= WIN_END_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_NUM_CP:  num_cp_ff  <= csr_pwdata[COUNT_BITS-1:0];
            REG_WIN_BEG: win_beg_ff <= csr_pwdata[TIME_BITS-1:0];
            REG_WIN_END: win_end_ff <= csr_pwdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_NUM_CP:  csr_prdata = CSR_DATA_W'(num_cp_ff);
         REG_WIN_BEG: csr_prdata = CSR_DATA_W'(win_beg_ff);
         REG_WIN_END: csr_prdata = CSR_DATA_W'(win_end_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (num_cp_ff < CP_MIN_C) begin
         count_eff = CP_MIN_C;
      end else if (num_cp_ff > CP_CAP_C) begin
         count_eff = CP_CAP_C;
      end else begin
         count_eff = num_cp_ff;
      end
      nseg = NSEG_W'(count_eff - COUNT_BITS'(3));
      span = win_end_ff - win_beg_ff;
   end

   // ---- datapath ----
   logic                 c_valid [QW+1];
   logic                 c_ready [QW+1];
   logic [TIME_BITS-1:0] c_rem   [QW+1];
   logic [NSEG_W-1:0]    c_lo    [QW+1];
   logic [QW-1:0]        c_quo   [QW+1];
   logic [CP_BITS-1:0]   c_cp    [QW+1];
   logic                 c_empty [QW+1];

   cbsw_front #(
      .NSEG_W (NSEG_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_word      (req_data),
      .window_start (win_beg_ff),
      .window_end   (win_end_ff),
      .nseg         (nseg),
      .out_valid    (c_valid[0]),
      .out_ready    (c_ready[0]),
      .out_rem      (c_rem[0]),
      .out_lo       (c_lo[0]),
      .out_cp       (c_cp[0]),
      .out_empty    (c_empty[0])
   );

   assign c_quo[0] = '0;

   for (genvar k = 0; k < QW; k++) begin : g_div
      cbsw_div_cell #(
         .NSEG_W (NSEG_W),
         .QW     (QW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .span      (span),
         .in_valid  (c_valid[k]),
         .in_ready  (c_ready[k]),
         .in_rem    (c_rem[k]),
         .in_lo     (c_lo[k]),
         .in_quo    (c_quo[k]),
         .in_cp     (c_cp[k]),
         .in_empty  (c_empty[k]),
         .out_valid (c_valid[k+1]),
         .out_ready (c_ready[k+1]),
         .out_rem   (c_rem[k+1]),
         .out_lo    (c_lo[k+1]),
         .out_quo   (c_quo[k+1]),
         .out_cp    (c_cp[k+1]),
         .out_empty (c_empty[k+1])
      );
   end

   cbsw_weight #(
      .NSEG_W (NSEG_W),
      .QW     (QW)
   ) u_weight (
      .clock     (clock),
      .reset     (reset),
      .nseg      (nseg),
      .in_valid  (c_valid[QW]),
      .in_ready  (c_ready[QW]),
      .in_quo    (c_quo[QW]),
      .in_cp     (c_cp[QW]),
      .in_empty  (c_empty[QW]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_data)
   );

   // final remainder and low bits are spent once the last cell is passed
   logic [TIME_BITS-1:0] tail_rem;
   logic [NSEG_W-1:0]    tail_lo;
   assign tail_rem = c_rem[QW];
   assign tail_lo  = c_lo[QW];

   a_tail_lo_spent: assert property (@(posedge clock) disable iff (reset)
      c_valid[QW] |-> tail_lo == '0 && (c_empty[QW] || tail_rem < span))
      else $error("divider tail not drained");

endmodule
`default_nettype wire

// File: src/cbsw_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbsw_front: time clamp and segment product
// Clamps the sample time to the window, subtracts the start and scales by
// the segment count; splits the product into the divider's start remainder
// and the low bits that the divider cells shift in.
// ---------------------------------------------------------------------------
module cbsw_front #(
   parameter int NSEG_W = 6
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  wire  cbsw_pkg::req_word_type        in_word,
   input  wire  [cbsw_pkg::TIME_BITS-1:0]      window_start,
   input  wire  [cbsw_pkg::TIME_BITS-1:0]      window_end,
   input  wire  [NSEG_W-1:0]                   nseg,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output logic [cbsw_pkg::TIME_BITS-1:0]      out_rem,
   output logic [NSEG_W-1:0]                   out_lo,
   output logic [cbsw_pkg::CP_BITS-1:0]        out_cp,
   output logic                                out_empty
);
   import cbsw_pkg::*;

   localparam int PW = TIME_BITS + NSEG_W;

   logic                 a_v_ff, b_v_ff;
   logic                 a_rdy, b_rdy;
   logic [TIME_BITS-1:0] tc;
   logic [TIME_BITS-1:0] diff_in, diff_ff;
   logic                 empty_in, empty_a_ff, empty_b_ff;
   logic [CP_BITS-1:0]   cp_a_ff, cp_b_ff;
   logic [PW-1:0]        prod_in, prod_ff;

   assign b_rdy    = !b_v_ff || out_ready;
   assign a_rdy    = !a_v_ff || b_rdy;
   assign in_ready = a_rdy;

   always_comb begin
      if (in_word.sample_time < window_start) begin
         tc = window_start;
      end else if (in_word.sample_time > window_end) begin
         tc = window_end;
      end else begin
         tc = in_word.sample_time;
      end
      diff_in  = tc - window_start;
      empty_in = !(window_end > window_start);
      prod_in  = PW'(diff_ff) * PW'(nseg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (a_rdy) begin
            a_v_ff <= in_valid;
         end
         if (b_rdy) begin
            b_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         diff_ff    <= diff_in;
         empty_a_ff <= empty_in;
         cp_a_ff    <= in_word.cp_index;
      end
      if (b_rdy) begin
         prod_ff    <= prod_in;
         empty_b_ff <= empty_a_ff;
         cp_b_ff    <= cp_a_ff;
      end
   end

   assign out_valid = b_v_ff;
   assign out_rem   = prod_ff[PW-1:NSEG_W];
   assign out_lo    = prod_ff[NSEG_W-1:0];
   assign out_cp    = cp_b_ff;
   assign out_empty = empty_b_ff;

endmodule
`default_nettype wire

// File: src/cbsw_div_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbsw_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the span
// when it fits and appends the quotient bit; registered toward the next cell.
// ---------------------------------------------------------------------------
module cbsw_div_cell #(
   parameter int NSEG_W = 6,
   parameter int QW     = 22
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [cbsw_pkg::TIME_BITS-1:0]   span,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire  [cbsw_pkg::TIME_BITS-1:0]   in_rem,
   input  wire  [NSEG_W-1:0]                in_lo,
   input  wire  [QW-1:0]                    in_quo,
   input  wire  [cbsw_pkg::CP_BITS-1:0]     in_cp,
   input  wire                              in_empty,
   output logic                             out_valid,
   input  wire                              out_ready,
   output logic [cbsw_pkg::TIME_BITS-1:0]   out_rem,
   output logic [NSEG_W-1:0]                out_lo,
   output logic [QW-1:0]                    out_quo,
   output logic [cbsw_pkg::CP_BITS-1:0]     out_cp,
   output logic                             out_empty
);
   import cbsw_pkg::*;

   logic                 v_ff;
   logic [TIME_BITS:0]   trial;
   logic                 fits;
   logic [TIME_BITS-1:0] rem_in, rem_ff;
   logic [NSEG_W-1:0]    lo_in, lo_ff;
   logic [QW-1:0]        quo_in, quo_ff;
   logic [CP_BITS-1:0]   cp_ff;
   logic                 empty_ff;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      trial  = {in_rem, in_lo[NSEG_W-1]};
      fits   = trial >= {1'b0, span};
      rem_in = fits ? TIME_BITS'(trial - {1'b0, span}) : trial[TIME_BITS-1:0];
      lo_in  = in_lo << 1;
      quo_in = {in_quo[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff   <= rem_in;
         lo_ff    <= lo_in;
         quo_ff   <= quo_in;
         cp_ff    <= in_cp;
         empty_ff <= in_empty;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_lo    = lo_ff;
   assign out_quo   = quo_ff;
   assign out_cp    = cp_ff;
   assign out_empty = empty_ff;

   // partial remainder must stay below the divisor
   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      v_ff && !empty_ff |-> rem_ff < span)
      else $error("divider remainder not below span");

endmodule
`default_nettype wire

// File: src/cbsw_weight.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbsw_weight: basis polynomial pipeline
// Turns the scaled quotient into segment and fraction, picks the basis
// branch for the requested point, forms x^2 and x^3 and divides by six.
// ---------------------------------------------------------------------------
module cbsw_weight #(
   parameter int NSEG_W = 6,
   parameter int QW     = 22
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [NSEG_W-1:0]                nseg,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire  [QW-1:0]                    in_quo,
   input  wire  [cbsw_pkg::CP_BITS-1:0]     in_cp,
   input  wire                              in_empty,
   output logic                             out_valid,
   input  wire                              out_ready,
   output cbsw_pkg::rsp_word_type           out_word
);
   import cbsw_pkg::*;

   localparam int F      = WEIGHT_FRAC_BITS;
   localparam int XW     = F + 1;
   localparam int VW     = WVAL_W;
   localparam int DW     = ((NSEG_W > CP_BITS) ? NSEG_W : CP_BITS) + 1;
   localparam int STAGES = 6;

   localparam logic [XW-1:0] ONE_Q = XW'(1) << F;

   // position of the point among the four active ones
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] rdy;

   // stage 1: segment, fraction and branch select
   logic [NSEG_W-1:0] seg_raw, seg;
   logic [XW-1:0]     u;
   logic [DW-1:0]     offset;
   logic [1:0]        pos;
   logic              sup_in, inner_in;
   logic [XW-1:0]     x_in;
   logic [XW-1:0]     x1_ff;
   logic              sup1_ff, inner1_ff;

   // stage 2: square
   logic [2*XW-1:0]   sq_full;
   logic [XW-1:0]     x2_in, x2_ff, xb_ff;
   logic              sup2_ff, inner2_ff;

   // stage 3: cube
   logic [2*XW-1:0]   cu_full;
   logic [XW-1:0]     x3_in, x3_ff, x2c_ff;
   logic              sup3_ff, inner3_ff;

   // stage 4: numerator
   logic [VW-1:0]     pos_sum, neg_sum, num_in, num4_ff;
   logic              sup4_ff;

   // stage 5: reciprocal product
   logic [2*VW-1:0]   prod_in, prod5_ff;
   logic [VW-1:0]     num5_ff;
   logic              sup5_ff;

   // stage 6: correction, output register
   logic [VW-1:0]     q0, rest, wq;
   logic [F-1:0]      weight_in, weight_ff;
   logic              sup6_ff;

   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      seg_raw = in_quo[QW-1:F];
      if (in_empty) begin
         seg = '0;
         u   = '0;
      end else if (seg_raw >= nseg) begin
         // time at the window end: last segment, u = 1
         seg = nseg - NSEG_W'(1);
         u   = ONE_Q;
      end else begin
         seg = seg_raw;
         u   = {1'b0, in_quo[F-1:0]};
      end
      offset   = DW'(in_cp) - DW'(seg);
      sup_in   = !offset[DW-1] && (offset <= DW'(3));
      pos      = offset[1:0];
      x_in     = (pos == POS_FIRST || pos == POS_THIRD) ? ONE_Q - u : u;
      inner_in = (pos == POS_SECOND || pos == POS_THIRD);
   end

   always_comb begin
      sq_full = (2*XW)'(x1_ff) * (2*XW)'(x1_ff);
      x2_in   = XW'(sq_full >> F);
      cu_full = (2*XW)'(x2_ff) * (2*XW)'(xb_ff);
      x3_in   = XW'(cu_full >> F);
   end

   always_comb begin
      pos_sum = (VW'(1) << (F + 2)) + (VW'(x3_ff) << 1) + VW'(x3_ff) + VW'(3);
      neg_sum = (VW'(x2c_ff) << 2) + (VW'(x2c_ff) << 1);
      if (!inner3_ff) begin
         num_in = VW'(x3_ff) + VW'(3);
      end else if (pos_sum >= neg_sum) begin
         num_in = pos_sum - neg_sum;
      end else begin
         num_in = '0;
      end
      prod_in = (2*VW)'(num4_ff) * (2*VW)'(RECIP6);
   end

   // quotient estimate is low by at most one
   always_comb begin
      q0        = prod5_ff[2*VW-1:VW];
      rest      = num5_ff - ((q0 << 2) + (q0 << 1));
      wq        = (rest >= VW'(6)) ? q0 + VW'(1) : q0;
      weight_in = sup5_ff ? wq[F-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x1_ff     <= x_in;
         sup1_ff   <= sup_in;
         inner1_ff <= inner_in;
      end
      if (rdy[1]) begin
         x2_ff     <= x2_in;
         xb_ff     <= x1_ff;
         sup2_ff   <= sup1_ff;
         inner2_ff <= inner1_ff;
      end
      if (rdy[2]) begin
         x3_ff     <= x3_in;
         x2c_ff    <= x2_ff;
         sup3_ff   <= sup2_ff;
         inner3_ff <= inner2_ff;
      end
      if (rdy[3]) begin
         num4_ff <= num_in;
         sup4_ff <= sup3_ff;
      end
      if (rdy[4]) begin
         prod5_ff <= prod_in;
         num5_ff  <= num4_ff;
         sup5_ff  <= sup4_ff;
      end
      if (rdy[5]) begin
         weight_ff <= weight_in;
         sup6_ff   <= sup5_ff;
      end
   end

   assign out_valid           = v_ff[STAGES-1];
   assign out_word.weight     = weight_ff;
   assign out_word.in_support = sup6_ff;

   a_x_unit: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> x1_ff <= ONE_Q)
      else $error("basis argument above one");

   a_unsupported_zero: assert property (@(posedge clock) disable iff (reset)
      v_ff[STAGES-1] && !sup6_ff |-> weight_ff == '0)
      else $error("weight nonzero outside support");

   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      v_ff[STAGES-1] |-> weight_ff <= WEIGHT_MAX)
      else $error("weight above basis maximum");

endmodule
`default_nettype wire
